// ===== sv/adcma_pkg.sv =====
// Package for the ADC moving-average block: widths, window size and
// saturation limits. No dependencies.
`timescale 1ns / 1ps

package adcma_pkg;

  // Window length; a power of two so the floor division is an arithmetic shift
  localparam int WINDOW      = 32;
  localparam int IDX_W       = $clog2(WINDOW);
  localparam int SAMPLE_BITS = 10;
  localparam int SCALE_SHIFT = 6;
  localparam int SCALED_W    = SAMPLE_BITS + SCALE_SHIFT;

  // Running sum / average and output widths
  localparam int RUN_W  = 22;
  localparam int AVG_W  = 18;
  localparam int HALF_W = AVG_W - 1;
  localparam int DISP_W = 14;

  // Tdata widths, padded to whole bytes
  localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((AVG_W + DISP_W + 7) / 8) * 8;

  // Divide by ten as multiply by ceil(2^19 / 10), exact for magnitudes below 2^18
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_TEN = RECIP_W'(52429);

  typedef logic signed [RUN_W-1:0] run_t;
  typedef logic signed [AVG_W-1:0] avg_t;

endpackage

// ===== sv/adc_moving_average_32_top.sv =====
// Top level of the ADC moving-average block: ring memory, running average
// update and display scaling. Depends on adcma_pkg.
//
//  channel  | dir | tdata fields (low bit up)                | tuser | tlast
//  s_axis   | in  | adc_sample[9:0], zero pad to 16 bits     |  -    |  -
//  m_axis   | out | average_q6[17:0], display_value[31:18]   |  -    |  -
//
// One sample is taken every cycle while the output is not stalled; a result passes
// in turn through ring read, average update, scaling, divide by ten and output.
// The first WINDOW samples after reset only fill the ring and give no result.
// Rate is set by the single read-modify-write of the 32-entry ring per sample;
// the ring needs no clearing, every entry is written before it is read.
// A stalled output register holds the whole pipeline, including s_axis_tready_o.
`timescale 1ns / 1ps

module adc_moving_average_32_top
  import adcma_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // adc_sample
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o    // average_q6, display_value
);

  localparam run_t RUN_MAX = run_t'((64'sd1 <<< (RUN_W - 1)) - 1);
  localparam run_t RUN_MIN = run_t'(-(64'sd1 <<< (RUN_W - 1)));
  localparam run_t AVG_MAX = run_t'((64'sd1 <<< (AVG_W - 1)) - 1);
  localparam run_t AVG_MIN = run_t'(-(64'sd1 <<< (AVG_W - 1)));

  logic en;
  logic accept;

  // Issue-side state
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             filled_q, filled_d;
  logic [SCALED_W-1:0] scaled;

  // Ring memory and its registered read port
  logic [SCALED_W-1:0] ring_mem [WINDOW];
  logic [SCALED_W-1:0] rd_q;

  // Update stage
  logic                valid1_q, fill1_q, last1_q;
  logic [SCALED_W-1:0] scaled1_q;
  run_t                rv_q, rv_d;
  logic signed [SCALED_W:0]   diff;
  logic signed [RUN_W:0]      sum_wide;
  run_t                       sum_sat;

  // Scaling stage
  logic                      valid2_q;
  run_t                      avg_run;
  avg_t                      avg2;
  logic signed [HALF_W-1:0]  half2;
  logic [HALF_W-1:0]         mag2;

  // Divide stage
  logic                      valid3_q, neg3_q;
  avg_t                      avg3_q;
  logic [HALF_W-1:0]         mag3_q;
  logic [HALF_W+RECIP_W-1:0] prod;
  logic [DISP_W-1:0]         quot;
  logic [DISP_W-1:0]         disp;

  // Output register
  logic              m_valid_q;
  avg_t              avg_out_q;
  logic [DISP_W-1:0] disp_out_q;

  // Advance everything unless a result is waiting and not taken
  assign en              = !m_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && en;
  assign s_axis_tready_o = en;
  assign scaled          = {s_axis_tdata_i[SAMPLE_BITS-1:0], SCALE_SHIFT'(0)};

  // Advance ring index and fill flag
  always_comb begin
    idx_d    = idx_q + IDX_W'(1);
    filled_d = filled_q || (idx_q == IDX_W'(WINDOW - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      filled_q <= 1'b0;
    end else if (accept) begin
      idx_q    <= idx_d;
      filled_q <= filled_d;
    end
  end

  // Read the oldest entry and replace it in the same transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q          <= ring_mem[idx_q];
      ring_mem[idx_q] <= scaled;
    end
  end

  // Carry the item into the update stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
    end else if (en) begin
      valid1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fill1_q   <= !filled_q;
      last1_q   <= (idx_q == IDX_W'(WINDOW - 1));
      scaled1_q <= scaled;
    end
  end

  // Accumulate during fill and divide by the window at its last sample, then add the floored difference
  always_comb begin
    diff = $signed({1'b0, scaled1_q}) - $signed({1'b0, rd_q});
    if (fill1_q) begin
      sum_wide = {rv_q[RUN_W-1], rv_q} + $signed({(RUN_W + 1 - SCALED_W)'(0), scaled1_q});
    end else begin
      sum_wide = {rv_q[RUN_W-1], rv_q} + (RUN_W + 1)'(diff >>> IDX_W);
    end
    if (sum_wide > $signed({RUN_MAX[RUN_W-1], RUN_MAX})) begin
      sum_sat = RUN_MAX;
    end else if (sum_wide < $signed({RUN_MIN[RUN_W-1], RUN_MIN})) begin
      sum_sat = RUN_MIN;
    end else begin
      sum_sat = sum_wide[RUN_W-1:0];
    end
    if (fill1_q && last1_q) begin
      rv_d = sum_sat >>> IDX_W;
    end else begin
      rv_d = sum_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q     <= '0;
      valid2_q <= 1'b0;
    end else if (en) begin
      if (valid1_q) begin
        rv_q <= rv_d;
      end
      valid2_q <= valid1_q && !fill1_q;
    end
  end

  // Clamp to the output range, halve and take the magnitude
  always_comb begin
    if (rv_q > AVG_MAX) begin
      avg_run = AVG_MAX;
    end else if (rv_q < AVG_MIN) begin
      avg_run = AVG_MIN;
    end else begin
      avg_run = rv_q;
    end
    avg2  = avg_run[AVG_W-1:0];
    half2 = avg2[AVG_W-1:1];
    mag2  = half2[HALF_W-1] ? HALF_W'(-half2) : HALF_W'(half2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid3_q <= 1'b0;
    end else if (en) begin
      valid3_q <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      avg3_q <= avg2;
      mag3_q <= mag2;
      neg3_q <= half2[HALF_W-1];
    end
  end

  // Divide the magnitude by ten and restore the sign
  always_comb begin
    prod = mag3_q * RECIP_TEN;
    quot = prod[RECIP_SHIFT +: DISP_W];
    disp = neg3_q ? -quot : quot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= valid3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid3_q) begin
      avg_out_q  <= avg3_q;
      disp_out_q <= disp;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({disp_out_q, avg_out_q});

endmodule

// ===== test/adcma_average_checker.sv =====
// Checker for the ADC moving-average block: watches both stream channels,
// predicts each average and display value, and compares them in order.
// Depends on adcma_pkg.
`timescale 1ns / 1ps

module adcma_average_checker
  import adcma_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // adc_sample
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata_i,   // average_q6, display_value
  output int                     error_count_o,
  output int                     pending_o
);

  localparam longint RunMax     = (longint'(1) <<< (RUN_W - 1)) - 1;
  localparam longint RunMin     = -(longint'(1) <<< (RUN_W - 1));
  localparam longint AvgMax     = (longint'(1) <<< (AVG_W - 1)) - 1;
  localparam longint AvgMin     = -(longint'(1) <<< (AVG_W - 1));
  localparam longint DisplayDiv = 10;
  localparam int     ReportMax  = 10;

  typedef logic signed [DISP_W-1:0] disp_t;

  typedef struct packed {
    avg_t  average_q6;
    disp_t display_value;
  } avg_result_t;

  avg_result_t         avg_expected_q[$];
  logic [SCALED_W-1:0] window_ring [WINDOW];
  logic [IDX_W-1:0]    write_slot;
  logic                window_full;
  longint              running_avg;
  int                  mismatches;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function void note_error(input string msg);
    mismatches++;
    if (mismatches <= ReportMax) $display("%0t: %s", $realtime, msg);
  endfunction

  // Fill the window, then slide it and queue the new average
  task automatic take_sample(input logic [SAMPLE_BITS-1:0] sample);
    logic [SCALED_W-1:0] scaled;
    longint              avg;
    avg_result_t         res;
    scaled = {sample, {SCALE_SHIFT{1'b0}}};
    if (!window_full) begin
      window_ring[write_slot] = scaled;
      running_avg = clamp(running_avg + longint'(scaled), RunMin, RunMax);
      if (write_slot == IDX_W'(WINDOW - 1)) begin
        window_full = 1'b1;
        running_avg = running_avg >>> IDX_W;
      end
      write_slot = write_slot + IDX_W'(1);
    end else begin
      // floor of the difference over the window length
      running_avg = clamp(running_avg +
                          ((longint'(scaled) - longint'(window_ring[write_slot])) >>> IDX_W),
                          RunMin, RunMax);
      window_ring[write_slot] = scaled;
      write_slot = write_slot + IDX_W'(1);
      avg = clamp(running_avg, AvgMin, AvgMax);
      res.average_q6    = avg_t'(avg);
      res.display_value = disp_t'((avg >>> 1) / DisplayDiv);
      avg_expected_q.push_back(res);
    end
  endtask

  // Compare one output transfer with the oldest expectation
  task automatic check_result(input logic [OUT_TDATA_W-1:0] data);
    avg_result_t want;
    avg_t        got_avg;
    disp_t       got_disp;
    got_avg  = data[AVG_W-1:0];
    got_disp = data[AVG_W +: DISP_W];
    if (avg_expected_q.size() == 0) begin
      note_error($sformatf("unexpected result: average_q6=%0d display_value=%0d",
                           got_avg, got_disp));
    end else begin
      want = avg_expected_q.pop_front();
      if (got_avg !== want.average_q6)
        note_error($sformatf("average_q6 mismatch: expected %0d, got %0d",
                             want.average_q6, got_avg));
      if (got_disp !== want.display_value)
        note_error($sformatf("display_value mismatch: expected %0d, got %0d",
                             want.display_value, got_disp));
    end
  endtask

  // Track inputs before outputs; a result never comes from the same edge's sample
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_expected_q.delete();
      write_slot    = '0;
      window_full   = 1'b0;
      running_avg   = 0;
      mismatches    = 0;
      error_count_o = 0;
      pending_o     = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) take_sample(s_axis_tdata_i[SAMPLE_BITS-1:0]);
      if (m_axis_tvalid_i && m_axis_tready_i) check_result(m_axis_tdata_i);
      error_count_o = mismatches;
      pending_o     = avg_expected_q.size();
    end
  end

endmodule

// ===== test/tb_adc_moving_average_32_top.sv =====
// Testbench top for the ADC moving-average block: clock, reset, sample
// stimulus, result back-pressure and verdict. Depends on adcma_pkg,
// adcma_average_checker and adc_moving_average_32_top.
`timescale 1ns / 1ps

module tb_adc_moving_average_32_top;
  import adcma_pkg::*;

  localparam int SampleTotal    = 1650;
  localparam int GapMax         = 11;
  localparam int PressureAt     = 300;
  localparam int PressureCycles = 400;
  localparam int IdleLimit      = 2000;
  localparam int DrainCycles    = 16;
  localparam int SampleMax      = (1 << SAMPLE_BITS) - 1;

  // Fill pattern: both extremes, alternating bits, walking ones and walking zeros
  localparam logic [SAMPLE_BITS-1:0] FillPattern [24] = '{
    10'd0, 10'd1023, 10'h155, 10'h2AA, 10'd1, 10'd2, 10'd4, 10'd8,
    10'd16, 10'd32, 10'd64, 10'd128, 10'd256, 10'd512, 10'd1022, 10'd1021,
    10'd1019, 10'd1015, 10'd1007, 10'd991, 10'd959, 10'd895, 10'd767, 10'd511
  };

  typedef enum int {
    PatUniform,
    PatFullScale,
    PatZero,
    PatNearLevel,
    PatToggle
  } sample_pattern_e;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  int                     error_count;
  int                     pending;
  int                     idle_cycles;

  adc_moving_average_32_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  adcma_average_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .error_count_o   (error_count),
    .pending_o       (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one sample after a gap, hold it until the transfer
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] sample, input int gap);
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(sample);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Stimulus: reset, directed fill, random segments, drain, verdict
  initial begin
    int              sent;
    int              seg_len;
    int              level;
    int              value;
    bit              burst;
    sample_pattern_e pattern;
    rst_n         = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (FillPattern[i]) send_sample(FillPattern[i], $urandom_range(0, GapMax));
    sent = $size(FillPattern);

    while (sent < SampleTotal) begin
      seg_len = $urandom_range(8, 80);
      pattern = sample_pattern_e'($urandom_range(0, 4));
      level   = $urandom_range(0, SampleMax);
      burst   = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < seg_len && sent < SampleTotal; k++) begin
        case (pattern)
          PatUniform:   value = $urandom_range(0, SampleMax);
          PatFullScale: value = SampleMax;
          PatZero:      value = 0;
          PatNearLevel: begin
            value = level + $urandom_range(0, 32) - 16;
            if (value < 0) value = 0;
            if (value > SampleMax) value = SampleMax;
          end
          default:      value = (k % 2 == 0) ? SampleMax : 0;
        endcase
        send_sample(SAMPLE_BITS'(value), burst ? 0 : $urandom_range(0, GapMax));
        sent++;
      end
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    // drain, then let the pipeline settle
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Receiver: random stalls, stall-free stretches and one long hold-off
  initial begin
    int gap;
    int results;
    bit burst;
    m_axis_tready = 1'b0;
    gap           = 0;
    results       = 0;
    burst         = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        gap--;
      end else begin
        m_axis_tready <= 1'b1;
      end
      @(posedge clk);
      if (m_axis_tready && m_axis_tvalid) begin
        results++;
        if (results % 48 == 0) burst = ($urandom_range(0, 2) == 0);
        if (results == PressureAt) gap = PressureCycles;
        else gap = burst ? 0 : $urandom_range(0, GapMax);
      end
    end
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

endmodule
